// ===== rtl/segment_segment_intersect_core_defines.svh =====
// ----------------------------------------------------------------------------
// Segment intersection core: assertion macros
// Implication checks used by the core, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_SEGMENT_INTERSECT_CORE_DEFINES_SVH
`define SEGMENT_SEGMENT_INTERSECT_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define SSI_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define SSI_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define SSI_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SSI_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/ssi_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment intersection package
// Shared constants for the segment intersection core.
// ----------------------------------------------------------------------------
`default_nettype none

package ssi_pkg;

    // coordinate width, signed, 4 fraction bits
    localparam int COORD_WIDTH_DEF = 16;
    localparam int COORD_WIDTH_MIN = 8;
    localparam int COORD_WIDTH_MAX = 32;

endpackage

`default_nettype wire

// ===== rtl/segment_segment_intersect_core.sv =====
// ----------------------------------------------------------------------------
// Segment intersection core
// Throughput: one transaction per cycle while m_ready does not stall; the
// scaling divider is unrolled into COORD_WIDTH stages, one quotient bit
// each, so nothing is shared.
// Each stage has its own valid and ready, bubbles are squeezed out on stall.
// Reset (aresetn low, synchronous) empties the pipeline; data is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "segment_segment_intersect_core_defines.svh"

module segment_segment_intersect_core #(
    parameter int COORD_WIDTH = ssi_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [COORD_WIDTH-1:0] s_a_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_a_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] s_a_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_a_end_y,
    input  wire logic signed [COORD_WIDTH-1:0] s_b_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_b_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] s_b_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_b_end_y,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_hit,
    output logic signed [COORD_WIDTH-1:0]      m_point_x,
    output logic signed [COORD_WIDTH-1:0]      m_point_y
);

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;          // coordinate difference
    localparam int PW = 2 * W + 2;      // product of two differences
    localparam int CW = 2 * W + 3;      // cross product
    localparam int NS = W + 5;          // S0, S1, S2, divider 0..W, output

    localparam int ST_DIV0 = 3;
    localparam int ST_OUT  = NS - 1;

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------
    function automatic logic [CW-1:0] mag_c(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] n;
        n = -v;
        return v[CW-1] ? $unsigned(n) : $unsigned(v);
    endfunction

    // n / d within [0, 1], d nonzero
    function automatic logic in_unit(input logic signed [CW-1:0] n,
                                     input logic signed [CW-1:0] d);
        return (n == '0) || ((n[CW-1] == d[CW-1]) && (mag_c(n) <= mag_c(d)));
    endfunction

    // one step of floor(a * b / c) with b <= c: returns {increment, remainder}
    function automatic logic [CW+1:0] div_step(input logic [CW-1:0] rem,
                                               input logic            abit,
                                               input logic [CW-1:0] b,
                                               input logic [CW-1:0] c);
        logic [CW+1:0] acc;
        logic [CW+1:0] c1;
        logic [CW+1:0] c2;
        logic [1:0]    inc;
        acc = {1'b0, rem, 1'b0} + (abit ? {2'b00, b} : '0);
        c1  = {2'b00, c};
        c2  = {1'b0, c, 1'b0};
        if (acc >= c2) begin
            inc = 2'd2;
            acc = acc - c2;
        end else if (acc >= c1) begin
            inc = 2'd1;
            acc = acc - c1;
        end else begin
            inc = 2'd0;
        end
        return {inc, acc[CW-1:0]};
    endfunction

    // ------------------------------------------------------------------------
    // stage handshake
    // ------------------------------------------------------------------------
    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS-1:0] stage_en;

    always_comb begin
        stage_en[NS-1] = !v_reg[NS-1] || m_ready;
        for (int i = NS - 2; i >= 0; i--) begin
            stage_en[i] = !v_reg[i] || stage_en[i+1];
        end
        v_next[0] = stage_en[0] ? s_valid : v_reg[0];
        for (int i = 1; i < NS; i++) begin
            v_next[i] = stage_en[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_ready = stage_en[0];
    assign m_valid = v_reg[ST_OUT];

    // ------------------------------------------------------------------------
    // S0: directions and offset
    // ------------------------------------------------------------------------
    logic signed [W-1:0]  s0_ax_reg, s0_ay_reg;
    logic signed [DW-1:0] s0_rx_reg, s0_ry_reg, s0_sx_reg, s0_sy_reg;
    logic signed [DW-1:0] s0_wx_reg, s0_wy_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            s0_ax_reg <= s_a_start_x;
            s0_ay_reg <= s_a_start_y;
            s0_rx_reg <= DW'(s_a_end_x) - DW'(s_a_start_x);
            s0_ry_reg <= DW'(s_a_end_y) - DW'(s_a_start_y);
            s0_sx_reg <= DW'(s_b_end_x) - DW'(s_b_start_x);
            s0_sy_reg <= DW'(s_b_end_y) - DW'(s_b_start_y);
            s0_wx_reg <= DW'(s_a_start_x) - DW'(s_b_start_x);
            s0_wy_reg <= DW'(s_a_start_y) - DW'(s_b_start_y);
        end
    end

    // ------------------------------------------------------------------------
    // S1: products
    // ------------------------------------------------------------------------
    logic signed [W-1:0]  s1_ax_reg, s1_ay_reg;
    logic signed [DW-1:0] s1_rx_reg, s1_ry_reg;
    logic signed [PW-1:0] s1_den0_reg, s1_den1_reg;
    logic signed [PW-1:0] s1_tn0_reg, s1_tn1_reg;
    logic signed [PW-1:0] s1_un0_reg, s1_un1_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            s1_ax_reg   <= s0_ax_reg;
            s1_ay_reg   <= s0_ay_reg;
            s1_rx_reg   <= s0_rx_reg;
            s1_ry_reg   <= s0_ry_reg;
            s1_den0_reg <= PW'(s0_rx_reg) * PW'(s0_sy_reg);
            s1_den1_reg <= PW'(s0_ry_reg) * PW'(s0_sx_reg);
            s1_tn0_reg  <= PW'(s0_sx_reg) * PW'(s0_wy_reg);
            s1_tn1_reg  <= PW'(s0_sy_reg) * PW'(s0_wx_reg);
            s1_un0_reg  <= PW'(s0_rx_reg) * PW'(s0_wy_reg);
            s1_un1_reg  <= PW'(s0_ry_reg) * PW'(s0_wx_reg);
        end
    end

    // ------------------------------------------------------------------------
    // S2: cross products
    // ------------------------------------------------------------------------
    logic signed [W-1:0]  s2_ax_reg, s2_ay_reg;
    logic signed [DW-1:0] s2_rx_reg, s2_ry_reg;
    logic signed [CW-1:0] s2_den_reg, s2_tn_reg, s2_un_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            s2_ax_reg  <= s1_ax_reg;
            s2_ay_reg  <= s1_ay_reg;
            s2_rx_reg  <= s1_rx_reg;
            s2_ry_reg  <= s1_ry_reg;
            s2_den_reg <= CW'(s1_den0_reg) - CW'(s1_den1_reg);
            s2_tn_reg  <= CW'(s1_tn0_reg) - CW'(s1_tn1_reg);
            s2_un_reg  <= CW'(s1_un0_reg) - CW'(s1_un1_reg);
        end
    end

    // ------------------------------------------------------------------------
    // divider stage 0: range test, magnitudes; stages 1..W: quotient bits
    // ------------------------------------------------------------------------
    logic signed [W-1:0] d_ax_reg   [W+1];
    logic signed [W-1:0] d_ay_reg   [W+1];
    logic                d_negx_reg [W+1];
    logic                d_negy_reg [W+1];
    logic [W-1:0]        d_magx_reg [W+1];
    logic [W-1:0]        d_magy_reg [W+1];
    logic                d_hit_reg  [W+1];
    logic [CW-1:0]       d_b_reg    [W+1];
    logic [CW-1:0]       d_c_reg    [W+1];
    logic [CW-1:0]       d_remx_reg [W+1];
    logic [CW-1:0]       d_remy_reg [W+1];
    logic [W-1:0]        d_qx_reg   [W+1];
    logic [W-1:0]        d_qy_reg   [W+1];

    logic                hit_next;
    logic signed [DW-1:0] rx_neg, ry_neg;

    always_comb begin
        hit_next = (s2_den_reg != '0) && in_unit(s2_tn_reg, s2_den_reg)
                   && in_unit(s2_un_reg, s2_den_reg);
        rx_neg   = -s2_rx_reg;
        ry_neg   = -s2_ry_reg;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_DIV0]) begin
            d_ax_reg[0]   <= s2_ax_reg;
            d_ay_reg[0]   <= s2_ay_reg;
            d_negx_reg[0] <= s2_rx_reg[DW-1];
            d_negy_reg[0] <= s2_ry_reg[DW-1];
            d_magx_reg[0] <= s2_rx_reg[DW-1] ? rx_neg[W-1:0] : s2_rx_reg[W-1:0];
            d_magy_reg[0] <= s2_ry_reg[DW-1] ? ry_neg[W-1:0] : s2_ry_reg[W-1:0];
            d_hit_reg[0]  <= hit_next;
            d_b_reg[0]    <= hit_next ? mag_c(s2_tn_reg) : '0;
            d_c_reg[0]    <= mag_c(s2_den_reg);
            d_remx_reg[0] <= '0;
            d_remy_reg[0] <= '0;
            d_qx_reg[0]   <= '0;
            d_qy_reg[0]   <= '0;
        end
    end

    for (genvar k = 1; k <= W; k++) begin : g_div
        logic [CW+1:0] stx, sty;
        logic [W-1:0]  qx_next, qy_next;

        always_comb begin
            stx = div_step(d_remx_reg[k-1], d_magx_reg[k-1][W-k],
                           d_b_reg[k-1], d_c_reg[k-1]);
            sty = div_step(d_remy_reg[k-1], d_magy_reg[k-1][W-k],
                           d_b_reg[k-1], d_c_reg[k-1]);
            qx_next = {d_qx_reg[k-1][W-2:0], 1'b0} + {{(W-2){1'b0}}, stx[CW+1:CW]};
            qy_next = {d_qy_reg[k-1][W-2:0], 1'b0} + {{(W-2){1'b0}}, sty[CW+1:CW]};
        end

        always_ff @(posedge aclk) begin
            if (stage_en[ST_DIV0+k]) begin
                d_ax_reg[k]   <= d_ax_reg[k-1];
                d_ay_reg[k]   <= d_ay_reg[k-1];
                d_negx_reg[k] <= d_negx_reg[k-1];
                d_negy_reg[k] <= d_negy_reg[k-1];
                d_magx_reg[k] <= d_magx_reg[k-1];
                d_magy_reg[k] <= d_magy_reg[k-1];
                d_hit_reg[k]  <= d_hit_reg[k-1];
                d_b_reg[k]    <= d_b_reg[k-1];
                d_c_reg[k]    <= d_c_reg[k-1];
                d_remx_reg[k] <= stx[CW-1:0];
                d_remy_reg[k] <= sty[CW-1:0];
                d_qx_reg[k]   <= qx_next;
                d_qy_reg[k]   <= qy_next;
            end
        end
    end

    // ------------------------------------------------------------------------
    // output: start point plus signed offset
    // ------------------------------------------------------------------------
    logic signed [DW-1:0] qx_s, qy_s, px_sum, py_sum;
    logic                 hit_reg;
    logic signed [W-1:0]  point_x_reg, point_y_reg;

    always_comb begin
        qx_s   = $signed({1'b0, d_qx_reg[W]});
        qy_s   = $signed({1'b0, d_qy_reg[W]});
        px_sum = DW'(d_ax_reg[W]) + (d_negx_reg[W] ? -qx_s : qx_s);
        py_sum = DW'(d_ay_reg[W]) + (d_negy_reg[W] ? -qy_s : qy_s);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_OUT]) begin
            hit_reg     <= d_hit_reg[W];
            point_x_reg <= d_hit_reg[W] ? px_sum[W-1:0] : '0;
            point_y_reg <= d_hit_reg[W] ? py_sum[W-1:0] : '0;
        end
    end

    assign m_hit     = hit_reg;
    assign m_point_x = point_x_reg;
    assign m_point_y = point_y_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `SSI_ASSERT_IMP(a_miss_zero, aclk, aresetn, m_valid && !m_hit,
        m_point_x == '0 && m_point_y == '0)
    `SSI_ASSERT_IMP(a_q_bound, aclk, aresetn, v_reg[ST_OUT-1] && d_hit_reg[W],
        d_qx_reg[W] <= d_magx_reg[W] && d_qy_reg[W] <= d_magy_reg[W])
    `SSI_ASSERT_IMP(a_rem_bound, aclk, aresetn, v_reg[ST_OUT-1] && d_hit_reg[W],
        d_remx_reg[W] < d_c_reg[W] && d_remy_reg[W] < d_c_reg[W])
    `SSI_ASSERT_NXT(a_out_load, aclk, aresetn, v_reg[ST_OUT-1] && stage_en[ST_OUT],
        m_valid)

endmodule

`default_nettype wire
